// ===== sv/sdq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared codes and control structs of the sorted deadline queue.
// ----------------------------------------------------------------------------
package sdq_pkg;

  // operation codes (input func field)
  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_TAKE   = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NOTAG = 2'd3;

  // field widths of the stream items
  localparam int unsigned FUNC_BITS   = 2;
  localparam int unsigned FIELD_KEY   = 32;
  localparam int unsigned TAG_BITS    = 8;
  localparam int unsigned STATUS_BITS = 2;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic ins;   // insert the broadcast key and tag
    logic scan;  // removal sweep is running
    logic head;  // sweep takes the head instead of matching a tag
    logic hit;   // sweep has already removed an entry
    logic stop;  // sweep ends this cycle
  } cell_ctl_t;

  // per-cell status seen by the sequencer
  typedef struct packed {
    logic tok;    // sweep token sits in this cell
    logic occ;    // token sits on a valid entry
    logic match;  // this cell is removed this cycle
  } cell_stat_t;

endpackage

// ===== sv/sorted_deadline_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_deadline_queue
// Queue of (key, tag) entries kept in ascending key order in a chain of cells.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis_*: insert a key and tag, take the head, or
// remove the entry nearest the head that carries a tag. Each item gives one
// result item on m_axis_*: status, removed key and tag, and the new count.
// An insert places the entry in the cycle after it is taken: every cell compares its key with
// the broadcast key and either holds, takes the new entry or shifts right.
// Inserts, empty removals and unused codes answer in the cycle after they are taken.
// Take head and remove by tag run a token down the chain, one cell a cycle;
// the matching cell empties and the cells behind it pull their right
// neighbors; the result is registered when the token stops at the first
// empty cell or at the tail.
// One item is worked on at a time; the next one is taken in the cycle after
// the sweep, when the result register is empty or is being read out.
// A stalled receiver holds the result and blocks s_axis_tready.
// Reset empties the queue (count zero) and drops any pending result.
// ----------------------------------------------------------------------------
module sorted_deadline_queue #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 32,
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1),
  localparam int unsigned OUT_BITS = sdq_pkg::STATUS_BITS + sdq_pkg::FIELD_KEY +
                                     sdq_pkg::TAG_BITS + CNT_BITS,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [47:0]      s_axis_tdata,   // func[1:0], key[33:2], tag[41:34], zero pad
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // status, out_key, out_tag, count, zero pad
);

  localparam int unsigned TB = sdq_pkg::TAG_BITS;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_BITS-1:0]    count_q, count_d;
  logic                   head_q, head_d;
  logic                   hit_q, hit_d;
  logic [TB-1:0]          tag_q, tag_d;
  logic [KEY_BITS-1:0]    res_key_q, res_key_d;
  logic [TB-1:0]          res_tag_q, res_tag_d;
  logic                   m_valid_q, m_valid_d;
  logic [OUT_W-1:0]       m_data_q, m_data_d;

  logic [1:0]             in_func;
  logic [63:0]            in_key_wide;
  logic [KEY_BITS-1:0]    in_key;
  logic [TB-1:0]          in_tag;
  logic                   fire;
  logic                   start;
  logic                   done;
  sdq_pkg::cell_ctl_t     ctl;

  logic [KEY_BITS-1:0]    key_w   [DEPTH];
  logic [TB-1:0]          tag_w   [DEPTH];
  logic [DEPTH-1:0]       valid_w;
  logic [DEPTH-1:0]       place_w;
  logic [DEPTH-1:0]       tok_w;
  sdq_pkg::cell_stat_t    stat_w  [DEPTH];

  logic                   match_any;
  logic                   occ_any;
  logic [KEY_BITS-1:0]    sel_key;
  logic [TB-1:0]          sel_tag;

  // result fields
  logic                   res_en;
  logic [1:0]             r_status;
  logic [KEY_BITS-1:0]    r_key;
  logic [TB-1:0]          r_tag;
  logic [63:0]            r_key_wide;

  assign in_func     = s_axis_tdata[1:0];
  assign in_key_wide = {32'd0, s_axis_tdata[33:2]};
  assign in_key      = in_key_wide[KEY_BITS-1:0];
  assign in_tag      = s_axis_tdata[41:34];

  assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
  assign fire          = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] l_key, r_key_n;
    logic [TB-1:0]       l_tag, r_tag_n;
    logic                l_valid, l_place, l_tok, r_valid, r_tok;

    if (i == 0) begin : g_first
      assign l_key   = '0;
      assign l_tag   = '0;
      assign l_valid = 1'b0;
      assign l_place = 1'b0;
      assign l_tok   = start;
    end else begin : g_mid_l
      assign l_key   = key_w[i-1];
      assign l_tag   = tag_w[i-1];
      assign l_valid = valid_w[i-1];
      assign l_place = place_w[i-1];
      assign l_tok   = tok_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_key_n = '0;
      assign r_tag_n = '0;
      assign r_valid = 1'b0;
      assign r_tok   = 1'b0;
    end else begin : g_mid_r
      assign r_key_n = key_w[i+1];
      assign r_tag_n = tag_w[i+1];
      assign r_valid = valid_w[i+1];
      assign r_tok   = tok_w[i+1];
    end

    sdq_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .ins_key_i(in_key),
      .tag_i    (ctl.scan ? tag_q : in_tag),
      .l_key_i  (l_key),
      .l_tag_i  (l_tag),
      .l_valid_i(l_valid),
      .l_place_i(l_place),
      .l_tok_i  (l_tok),
      .r_key_i  (r_key_n),
      .r_tag_i  (r_tag_n),
      .r_valid_i(r_valid),
      .r_tok_i  (r_tok),
      .key_o    (key_w[i]),
      .tag_o    (tag_w[i]),
      .valid_o  (valid_w[i]),
      .place_o  (place_w[i]),
      .tok_o    (tok_w[i]),
      .stat_o   (stat_w[i])
    );
  end

  // one-hot pick of the removed entry and token status
  always_comb begin
    match_any = 1'b0;
    occ_any   = 1'b0;
    sel_key   = '0;
    sel_tag   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match_any = match_any | stat_w[i].match;
      occ_any   = occ_any | stat_w[i].occ;
      sel_key   = sel_key | (stat_w[i].match ? key_w[i] : '0);
      sel_tag   = sel_tag | (stat_w[i].match ? tag_w[i] : '0);
    end
  end

  // sweep ends at the first empty cell or at the tail
  assign done = (state_q == S_SCAN) && (stat_w[DEPTH-1].tok || !occ_any);

  // ---------------------------------------------------------- sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    head_d    = head_q;
    hit_d     = hit_q;
    tag_d     = tag_q;
    res_key_d = res_key_q;
    res_tag_d = res_tag_q;
    start     = 1'b0;
    res_en    = 1'b0;
    r_status  = sdq_pkg::ST_OK;
    r_key     = '0;
    r_tag     = '0;
    ctl       = '0;
    ctl.head  = head_q;
    ctl.hit   = hit_q;

    case (state_q)
      S_IDLE: begin
        if (fire) begin
          case (in_func)
            sdq_pkg::FN_INSERT: begin
              res_en = 1'b1;
              if (count_q == CNT_BITS'(DEPTH)) begin
                r_status = sdq_pkg::ST_FULL;
              end else begin
                ctl.ins = 1'b1;
                count_d = count_q + CNT_BITS'(1);
              end
            end
            sdq_pkg::FN_TAKE, sdq_pkg::FN_REMOVE: begin
              if (count_q == '0) begin
                res_en   = 1'b1;
                r_status = sdq_pkg::ST_EMPTY;
              end else begin
                start   = 1'b1;
                head_d  = (in_func == sdq_pkg::FN_TAKE);
                hit_d   = 1'b0;
                tag_d   = in_tag;
                state_d = S_SCAN;
              end
            end
            default: begin
              res_en = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        ctl.stop = done;
        if (match_any) begin
          hit_d     = 1'b1;
          res_key_d = sel_key;
          res_tag_d = sel_tag;
        end
        if (done) begin
          res_en  = 1'b1;
          state_d = S_IDLE;
          if (hit_q || match_any) begin
            r_key   = match_any ? sel_key : res_key_q;
            r_tag   = match_any ? sel_tag : res_tag_q;
            count_d = count_q - CNT_BITS'(1);
          end else begin
            r_status = sdq_pkg::ST_NOTAG;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------- result reg
  always_comb begin
    r_key_wide                 = '0;
    r_key_wide[KEY_BITS-1:0]   = r_key;
    m_data_d                   = m_data_q;
    m_valid_d                  = m_valid_q && !m_axis_tready;
    if (res_en) begin
      m_valid_d = 1'b1;
      m_data_d  = '0;
      m_data_d[1:0]                 = r_status;
      m_data_d[33:2]                = r_key_wide[31:0];
      m_data_d[41:34]               = r_tag;
      m_data_d[42+CNT_BITS-1:42]    = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      hit_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      hit_q     <= hit_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q    <= head_d;
    tag_q     <= tag_d;
    res_key_q <= res_key_d;
    res_tag_q <= res_tag_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(DEPTH))
    else $error("entry count above depth");

  a_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_w))
    else $error("more than one sweep token in the chain");

  a_idle_no_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (tok_w == '0))
    else $error("sweep token left behind after a removal");

  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(valid_w) == int'(count_q)))
    else $error("valid cells disagree with the entry count");
`endif

endmodule

// ===== sv/sdq_cell.sv =====
// ----------------------------------------------------------------------------
// sdq_cell
// One slot of the sorted chain: holds an entry, opens a gap for an insert
// and closes a gap behind a removal by pulling from its right neighbor.
// ----------------------------------------------------------------------------
module sdq_cell #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sdq_pkg::cell_ctl_t            ctl_i,
  input  logic [KEY_BITS-1:0]           ins_key_i,
  input  logic [sdq_pkg::TAG_BITS-1:0]  tag_i,
  // left neighbor (toward the head)
  input  logic [KEY_BITS-1:0]           l_key_i,
  input  logic [sdq_pkg::TAG_BITS-1:0]  l_tag_i,
  input  logic                          l_valid_i,
  input  logic                          l_place_i,
  input  logic                          l_tok_i,
  // right neighbor (toward the tail)
  input  logic [KEY_BITS-1:0]           r_key_i,
  input  logic [sdq_pkg::TAG_BITS-1:0]  r_tag_i,
  input  logic                          r_valid_i,
  input  logic                          r_tok_i,
  output logic [KEY_BITS-1:0]           key_o,
  output logic [sdq_pkg::TAG_BITS-1:0]  tag_o,
  output logic                          valid_o,
  output logic                          place_o,
  output logic                          tok_o,
  output sdq_pkg::cell_stat_t           stat_o
);

  logic [KEY_BITS-1:0]          key_q, key_d;
  logic [sdq_pkg::TAG_BITS-1:0] tag_q, tag_d;
  logic                         valid_q, valid_d;
  logic                         tok_q, tok_d;
  logic                         match;

  // new entry belongs here or further toward the head
  assign place_o = !valid_q || (key_q >= ins_key_i);

  assign match = ctl_i.scan && tok_q && valid_q && !ctl_i.hit &&
                 (ctl_i.head || (tag_q == tag_i));

  always_comb begin
    key_d   = key_q;
    tag_d   = tag_q;
    valid_d = valid_q;
    tok_d   = l_tok_i && !ctl_i.stop;
    if (ctl_i.ins) begin
      if (l_place_i) begin
        key_d   = l_key_i;
        tag_d   = l_tag_i;
        valid_d = l_valid_i;
      end else if (place_o) begin
        key_d   = ins_key_i;
        tag_d   = tag_i;
        valid_d = 1'b1;
      end
    end else if (ctl_i.scan) begin
      if (ctl_i.hit && r_tok_i) begin
        key_d   = r_key_i;
        tag_d   = r_tag_i;
        valid_d = r_valid_i;
      end else if (tok_q && (ctl_i.hit || match)) begin
        // gap moves right, refilled next cycle by the neighbor pull
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o        = key_q;
  assign tag_o        = tag_q;
  assign valid_o      = valid_q;
  assign tok_o        = tok_q;
  assign stat_o.tok   = tok_q;
  assign stat_o.occ   = tok_q && valid_q;
  assign stat_o.match = match;

endmodule

// ===== tb/tb_sorted_deadline_queue.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_deadline_queue
// Self-checking bench for the sorted deadline queue.
// ----------------------------------------------------------------------------
// A short table of directed items covers the empty, full and no-match cases,
// equal keys, duplicate tags, the unused code and the key and tag extremes.
// After it come random inserts, takes and removals that steer the queue
// between empty and full. A queue model in the bench predicts every result.
// Both stream sides idle at random in two phases, the receiver holds off
// for a long stretch once, and the sender stops until all results are back.
// ----------------------------------------------------------------------------
module tb_sorted_deadline_queue;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned PHASE_ITEMS  = 310;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned LIMIT_CYCLES = 400000;

  // func code that the block ignores
  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      key;
    logic [7:0]       tag;
    logic [CNT_W-1:0] count;
  } sdq_result_t;

  typedef struct packed {
    logic [1:0]  fn;
    logic [31:0] key;
    logic [7:0]  tag;
    int          reps;
    bit          typed;
    sdq_result_t want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 15;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{sdq_pkg::FN_TAKE,   32'h0000_0000, 8'h00, 1,  1'b1,
      '{sdq_pkg::ST_EMPTY, 32'h0, 8'h0, 5'd0}},
    '{sdq_pkg::FN_REMOVE, 32'h0000_0000, 8'h00, 1,  1'b1,
      '{sdq_pkg::ST_EMPTY, 32'h0, 8'h0, 5'd0}},
    '{FN_UNUSED,          32'hffff_ffff, 8'hff, 1,  1'b1,
      '{sdq_pkg::ST_OK,    32'h0, 8'h0, 5'd0}},
    '{sdq_pkg::FN_INSERT, 32'hffff_ffff, 8'hff, 1,  1'b1,
      '{sdq_pkg::ST_OK,    32'h0, 8'h0, 5'd1}},
    '{sdq_pkg::FN_INSERT, 32'h0000_0000, 8'h00, 1,  1'b1,
      '{sdq_pkg::ST_OK,    32'h0, 8'h0, 5'd2}},
    '{sdq_pkg::FN_INSERT, 32'h8000_0000, 8'h5a, 1,  1'b0, '0},
    // equal key: newest goes in front
    '{sdq_pkg::FN_INSERT, 32'h8000_0000, 8'ha5, 1,  1'b0, '0},
    '{sdq_pkg::FN_REMOVE, 32'h0000_0000, 8'h77, 1,  1'b1,
      '{sdq_pkg::ST_NOTAG, 32'h0, 8'h0, 5'd4}},
    // duplicate tag: the one nearest the head goes
    '{sdq_pkg::FN_INSERT, 32'h0000_000a, 8'h5a, 1,  1'b0, '0},
    '{sdq_pkg::FN_REMOVE, 32'h0000_0000, 8'h5a, 1,  1'b0, '0},
    '{sdq_pkg::FN_TAKE,   32'h0000_0000, 8'h00, 1,  1'b0, '0},
    '{FN_UNUSED,          32'hffff_ffff, 8'hff, 1,  1'b0, '0},
    '{sdq_pkg::FN_INSERT, 32'h0000_1234, 8'h33, 13, 1'b0, '0},
    '{sdq_pkg::FN_INSERT, 32'h5555_5555, 8'hc3, 1,  1'b1,
      '{sdq_pkg::ST_FULL,  32'h0, 8'h0, 5'd16}},
    // tag of the tail entry
    '{sdq_pkg::FN_REMOVE, 32'h0000_0000, 8'hff, 1,  1'b0, '0}
  };

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [47:0]      s_axis_tdata  = '0;   // func[1:0], key[33:2], tag[41:34], zero pad
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [47:0]      m_axis_tdata;         // status, out_key, out_tag, count, zero pad

  // queue model
  logic [31:0]      held_keys [DEPTH];
  logic [7:0]       held_tags [DEPTH];
  int unsigned      held;

  sdq_result_t      pending_q [$];
  int unsigned      errors;
  int unsigned      cycles;
  int unsigned      tx_idle_pct;
  int unsigned      rx_idle_pct;
  bit               hold_pending;
  int unsigned      op_hits [4];
  int unsigned      status_hits [4];

  sorted_deadline_queue #(
    .DEPTH    (DEPTH),
    .KEY_BITS (32)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic void report(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // applies one operation to the queue model and returns its result
  function automatic sdq_result_t apply_op(logic [1:0] fn, logic [31:0] key,
                                           logic [7:0] tag);
    sdq_result_t r;
    int          pos;
    int          i;
    r = '0;
    r.status = sdq_pkg::ST_OK;
    case (fn)
      sdq_pkg::FN_INSERT: begin
        if (held == DEPTH) begin
          r.status = sdq_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < held && held_keys[pos] < key) pos++;
          for (i = held; i > pos; i--) begin
            held_keys[i] = held_keys[i-1];
            held_tags[i] = held_tags[i-1];
          end
          held_keys[pos] = key;
          held_tags[pos] = tag;
          held++;
        end
      end
      sdq_pkg::FN_TAKE, sdq_pkg::FN_REMOVE: begin
        if (held == 0) begin
          r.status = sdq_pkg::ST_EMPTY;
        end else begin
          pos = -1;
          if (fn == sdq_pkg::FN_TAKE) pos = 0;
          for (i = 0; i < held && pos < 0; i++) begin
            if (held_tags[i] == tag) pos = i;
          end
          if (pos < 0) begin
            r.status = sdq_pkg::ST_NOTAG;
          end else begin
            r.key = held_keys[pos];
            r.tag = held_tags[pos];
            for (i = pos; i + 1 < held; i++) begin
              held_keys[i] = held_keys[i+1];
              held_tags[i] = held_tags[i+1];
            end
            held--;
          end
        end
      end
      default: ;
    endcase
    r.count = held[CNT_W-1:0];
    op_hits[fn]++;
    status_hits[r.status]++;
    return r;
  endfunction

  task automatic send_item(input logic [1:0] fn, input logic [31:0] key, input logic [7:0] tag,
                           input bit typed, input sdq_result_t want);
    sdq_result_t model;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, tag, key, fn};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    model = apply_op(fn, key, tag);
    pending_q.push_back(typed ? want : model);
  endtask

  // sender stops until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_pending = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    sdq_result_t got;
    sdq_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[1:0];
      got.key    = m_axis_tdata[33:2];
      got.tag    = m_axis_tdata[41:34];
      got.count  = m_axis_tdata[42 +: CNT_W];
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result: status %0d key %h tag %h count %0d",
                         got.status, got.key, got.tag, got.count));
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          report($sformatf({"mismatch: expected status %0d key %h tag %h count %0d,",
                            " got %0d %h %h %0d"},
                           want.status, want.key, want.tag, want.count,
                           got.status, got.key, got.tag, got.count));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned i;
    int          n;
    int unsigned r;
    bit          filling;
    logic [1:0]  fn;
    logic [31:0] key;
    logic [7:0]  tag;
    filling = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_ROWS; i++) begin
      for (n = 0; n < DIRECTED[i].reps; n++) begin
        send_item(DIRECTED[i].fn, DIRECTED[i].key, DIRECTED[i].tag,
                  DIRECTED[i].typed, DIRECTED[i].want);
      end
    end
    drain();

    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 87 : 0;
      rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 37 : 0;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // long receiver stall while items keep coming
        if (phase == 2 && i == 60) hold_pending = 1'b1;
        // walk the fill level up to full and down to empty in turns
        if (held == DEPTH) filling = 1'b0;
        else if (held == 0) filling = 1'b1;
        else if ($urandom_range(39) == 0) filling = !filling;
        r = $urandom_range(99);
        if (r < 2) fn = FN_UNUSED;
        else if (r < (filling ? 70 : 30)) fn = sdq_pkg::FN_INSERT;
        else if (r < (filling ? 85 : 65)) fn = sdq_pkg::FN_TAKE;
        else fn = sdq_pkg::FN_REMOVE;
        r = $urandom_range(9);
        if (r < 4) begin
          key = $urandom_range(31);
        end else if (r < 6) begin
          case ($urandom_range(3))
            0: key = 32'h0000_0000;
            1: key = 32'hffff_ffff;
            2: key = 32'h7fff_ffff;
            default: key = 32'h8000_0000;
          endcase
        end else begin
          key = $urandom;
        end
        if (fn == sdq_pkg::FN_REMOVE && held != 0 && $urandom_range(9) < 7) begin
          tag = held_tags[$urandom_range(held - 1)];
        end else if ($urandom_range(1) == 0) begin
          tag = $urandom_range(15);
        end else begin
          tag = $urandom_range(255);
        end
        send_item(fn, key, tag, 1'b0, '0);
        if (i == PHASE_ITEMS / 2) drain();
      end
      drain();
    end

    repeat (DEPTH + 8) @(posedge clk_i);
    $display("ran %0d items: %0d inserts, %0d takes, %0d removals, %0d unused codes",
             op_hits[0] + op_hits[1] + op_hits[2] + op_hits[3],
             op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
    $display("outcomes: %0d ok, %0d empty, %0d refused full, %0d tag misses, %0d errors",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sdq_pkg.sv
sv/sdq_cell.sv
sv/sorted_deadline_queue.sv
tb/tb_sorted_deadline_queue.sv
